@@ hw/rtl/pipc_pkg.sv @@
// ============================================================================
// pipc_pkg
// Shared types and constants for the point-in-polygon crossing test block.
// ============================================================================
package pipc_pkg;

    // Coordinate widths, degrees times ten million.
    localparam int LAT_W      = 31;
    localparam int LON_W      = 32;

    // Configuration port geometry.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TEST_LAT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEST_LON     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDE_MODE = 2'd2;

    // Crossing flag bit positions.
    localparam int FLAG_W           = 7;
    localparam int FLAG_INSIDE      = 0;
    localparam int FLAG_LIMBO       = 1;
    localparam int FLAG_LIMBO_UP    = 2;
    localparam int FLAG_LIMBO_BEGIN = 3;
    localparam int FLAG_BEGIN_UP    = 4;
    localparam int FLAG_BEGIN_HOR   = 5;
    localparam int FLAG_UP          = 6;

    typedef logic [FLAG_W-1:0] flags_t;

    // One polygon vertex item.
    typedef struct packed {
        logic signed [LAT_W-1:0] vertex_lat;
        logic signed [LON_W-1:0] vertex_lon;
        logic                    restart;
    } vertex_t;

    // One result item.
    typedef struct packed {
        logic inside_res;
        logic keep;
        logic closed;
        logic unresolved;
    } result_t;

    // Edge classification handed to the flag update logic.
    typedef struct packed {
        logic a1_eq;   // previous vertex latitude equals test latitude
        logic a1_lt;   // previous vertex latitude below test latitude
        logic a2_eq;   // current vertex latitude equals test latitude
        logic a2_lt;   // current vertex latitude below test latitude
        logic o1_gt;   // previous vertex longitude right of test longitude
        logic o2_gt;   // current vertex longitude right of test longitude
        logic right;   // diagonal edge crosses the ray right of the test point
        logic first;   // first edge of the polygon
        logic last;    // edge that closes the polygon
    } edge_cmp_t;

endpackage

@@ hw/rtl/pipc_stream_if.sv @@
// ============================================================================
// pipc_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ============================================================================
interface pipc_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ hw/rtl/pipc_edge_update.sv @@
// ============================================================================
// pipc_edge_update
// Crossing flag update for one polygon edge against the horizontal test ray.
// ============================================================================
module pipc_edge_update
    import pipc_pkg::*;
(
    input  flags_t    flags_in,
    input  edge_cmp_t cmp,
    output flags_t    flags_out
);

    flags_t s;

    always_comb
    begin
        s = flags_in;
        if (cmp.a1_eq)
        begin
            // Edge starts on the ray line.
            if (cmp.a2_lt)
            begin
                // Leaves downward.
                if (s[FLAG_LIMBO])
                begin
                    if (s[FLAG_LIMBO_UP])
                    begin
                        s[FLAG_INSIDE] = ~s[FLAG_INSIDE];
                    end
                    s[FLAG_LIMBO]    = 1'b0;
                    s[FLAG_LIMBO_UP] = 1'b0;
                end
                else if (s[FLAG_LIMBO_BEGIN])
                begin
                    if (s[FLAG_BEGIN_HOR])
                    begin
                        s[FLAG_BEGIN_HOR] = 1'b0;
                    end
                    else if (cmp.last)
                    begin
                        if (s[FLAG_BEGIN_UP])
                        begin
                            s[FLAG_INSIDE] = ~s[FLAG_INSIDE];
                        end
                        s[FLAG_LIMBO_BEGIN] = 1'b0;
                        s[FLAG_BEGIN_UP]    = 1'b0;
                    end
                end
                else if (cmp.first && cmp.o1_gt)
                begin
                    s[FLAG_LIMBO_BEGIN] = 1'b1;
                end
            end
            else if (cmp.a2_eq)
            begin
                // Horizontal edge along the ray line.
                if (cmp.first && (cmp.o1_gt || cmp.o2_gt))
                begin
                    s[FLAG_LIMBO_BEGIN] = 1'b1;
                    s[FLAG_BEGIN_HOR]   = 1'b1;
                end
                else if (cmp.last && s[FLAG_LIMBO_BEGIN] && s[FLAG_LIMBO])
                begin
                    if (s[FLAG_LIMBO_UP] != s[FLAG_BEGIN_UP])
                    begin
                        s[FLAG_INSIDE] = ~s[FLAG_INSIDE];
                    end
                    s[FLAG_LIMBO]       = 1'b0;
                    s[FLAG_LIMBO_UP]    = 1'b0;
                    s[FLAG_LIMBO_BEGIN] = 1'b0;
                    s[FLAG_BEGIN_UP]    = 1'b0;
                end
                else if (s[FLAG_LIMBO])
                begin
                    s = s;
                end
                else if (!cmp.o1_gt && cmp.o2_gt)
                begin
                    if (s[FLAG_UP])
                    begin
                        s[FLAG_UP]       = 1'b0;
                        s[FLAG_LIMBO_UP] = 1'b1;
                    end
                    s[FLAG_LIMBO] = 1'b1;
                end
            end
            else
            begin
                // Leaves upward.
                if (s[FLAG_LIMBO])
                begin
                    if (!s[FLAG_LIMBO_UP])
                    begin
                        s[FLAG_INSIDE] = ~s[FLAG_INSIDE];
                    end
                    s[FLAG_LIMBO]    = 1'b0;
                    s[FLAG_LIMBO_UP] = 1'b0;
                end
                else if (s[FLAG_LIMBO_BEGIN])
                begin
                    if (s[FLAG_BEGIN_HOR])
                    begin
                        s[FLAG_BEGIN_HOR] = 1'b0;
                        s[FLAG_BEGIN_UP]  = 1'b1;
                    end
                    else if (cmp.last)
                    begin
                        if (!s[FLAG_BEGIN_UP])
                        begin
                            s[FLAG_INSIDE] = ~s[FLAG_INSIDE];
                        end
                        s[FLAG_LIMBO_BEGIN] = 1'b0;
                        s[FLAG_BEGIN_UP]    = 1'b0;
                    end
                end
                else if (cmp.first && cmp.o1_gt)
                begin
                    s[FLAG_LIMBO_BEGIN] = 1'b1;
                    s[FLAG_BEGIN_UP]    = 1'b1;
                end
            end
            s[FLAG_UP] = 1'b0;
        end
        else if (cmp.a2_eq)
        begin
            // Edge ends on the ray line.
            if (cmp.a1_lt)
            begin
                if (cmp.last)
                begin
                    if (s[FLAG_BEGIN_UP])
                    begin
                        s[FLAG_INSIDE] = ~s[FLAG_INSIDE];
                    end
                    s[FLAG_LIMBO_BEGIN] = 1'b0;
                    s[FLAG_BEGIN_UP]    = 1'b0;
                end
                else if (cmp.o2_gt)
                begin
                    s[FLAG_LIMBO] = 1'b1;
                end
            end
            else
            begin
                if (cmp.last)
                begin
                    if (!s[FLAG_BEGIN_UP])
                    begin
                        s[FLAG_INSIDE] = ~s[FLAG_INSIDE];
                    end
                    s[FLAG_LIMBO_BEGIN] = 1'b0;
                    s[FLAG_BEGIN_UP]    = 1'b0;
                end
                else if (cmp.o2_gt)
                begin
                    s[FLAG_LIMBO]    = 1'b1;
                    s[FLAG_LIMBO_UP] = 1'b1;
                end
                else
                begin
                    s[FLAG_UP] = 1'b1;
                end
            end
        end
        else if (cmp.a1_lt != cmp.a2_lt)
        begin
            // Edge passes strictly through the ray line.
            if (cmp.o1_gt && cmp.o2_gt)
            begin
                s[FLAG_INSIDE] = ~s[FLAG_INSIDE];
            end
            else if ((cmp.o1_gt || cmp.o2_gt) && cmp.right)
            begin
                s[FLAG_INSIDE] = ~s[FLAG_INSIDE];
            end
        end
        flags_out = s;
    end

endmodule

@@ hw/rtl/point_in_polygon_crossing_test_top.sv @@
// ============================================================================
// point_in_polygon_crossing_test_top
// Crossing-number point-in-polygon test against one configured test point.
// ============================================================================
// Usage:
//   Write the test point (latitude, longitude) and the exclude mode through
//   the configuration port while the block is idle. Then stream polygon
//   vertices on the vertex channel; each vertex item yields exactly one
//   result item on the result channel with the running inside bit, the keep
//   decision, a closed flag and an unresolved flag. A vertex equal to the
//   opening vertex closes the polygon; later polygons XOR into the same
//   inside bit. Setting restart on a vertex clears all kept state first.
//   A vertex passes stage 1, stage 2 and the result register before its
//   result item becomes valid. While the result receiver takes every item,
//   throughput is one vertex per cycle: the only loop is the seven
//   flag bits and the hit bit, which are updated in the last stage, and the
//   two 33 by 32 bit cross products sit in a stage of their own.
//   When the result receiver stalls, the pipeline fills and vertex ready
//   drops; no item is lost. Reset clears the configuration registers to
//   zero, leaves no polygon open and clears the crossing flags and hit bit.
// ============================================================================
module point_in_polygon_crossing_test_top
    import pipc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pipc_stream_if.sink           vertex,
    pipc_stream_if.source         result
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [LAT_W-1:0] test_lat_reg;
    logic signed [LON_W-1:0] test_lon_reg;
    logic                    exclude_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            test_lat_reg     <= '0;
            test_lon_reg     <= '0;
            exclude_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TEST_LAT:     test_lat_reg     <= $signed(cfg_data[LAT_W-1:0]);
                CFG_TEST_LON:     test_lon_reg     <= $signed(cfg_data[LON_W-1:0]);
                CFG_EXCLUDE_MODE: exclude_mode_reg <= cfg_data[0];
                default:          test_lat_reg     <= test_lat_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage moves when the next has room.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s2_free;
    logic s1_free;
    logic s1_adv;
    logic s2_adv;
    logic accept;

    assign out_free     = !out_valid_reg || result.ready;
    assign s2_free      = !s2_valid_reg || out_free;
    assign s1_free      = !s1_valid_reg || s2_free;
    assign s2_adv       = s2_valid_reg && out_free;
    assign s1_adv       = s1_valid_reg && s2_free;
    assign vertex.ready = s1_free;
    assign accept       = vertex.valid && s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= vertex.valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Polygon tracking at accept: opening vertex, previous vertex, closing.
    // ------------------------------------------------------------------
    logic                    open_reg;
    logic                    first_reg;
    logic signed [LAT_W-1:0] start_lat_reg;
    logic signed [LON_W-1:0] start_lon_reg;
    logic signed [LAT_W-1:0] prev_lat_reg;
    logic signed [LON_W-1:0] prev_lon_reg;

    logic open_eff;
    logic first_eff;
    logic in_last;
    logic in_hit;
    logic open_next;
    logic first_next;

    assign open_eff  = open_reg && !vertex.data.restart;
    assign first_eff = first_reg || vertex.data.restart;
    assign in_last   = (vertex.data.vertex_lat == start_lat_reg)
                    && (vertex.data.vertex_lon == start_lon_reg);
    assign in_hit    = (vertex.data.vertex_lat == test_lat_reg)
                    && (vertex.data.vertex_lon == test_lon_reg);

    always_comb
    begin
        open_next  = 1'b1;
        first_next = first_eff;
        if (open_eff)
        begin
            open_next  = !in_last;
            first_next = in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            first_reg <= 1'b1;
        end
        else if (accept)
        begin
            open_reg  <= open_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!open_eff)
            begin
                start_lat_reg <= vertex.data.vertex_lat;
                start_lon_reg <= vertex.data.vertex_lon;
            end
            if (!(open_eff && in_last))
            begin
                prev_lat_reg <= vertex.data.vertex_lat;
                prev_lon_reg <= vertex.data.vertex_lon;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: edge endpoints and edge context.
    // ------------------------------------------------------------------
    logic signed [LAT_W-1:0] s1_a1_reg;
    logic signed [LON_W-1:0] s1_o1_reg;
    logic signed [LAT_W-1:0] s1_a2_reg;
    logic signed [LON_W-1:0] s1_o2_reg;
    logic                    s1_edge_reg;
    logic                    s1_first_reg;
    logic                    s1_last_reg;
    logic                    s1_hit_reg;
    logic                    s1_restart_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_a1_reg      <= prev_lat_reg;
            s1_o1_reg      <= prev_lon_reg;
            s1_a2_reg      <= vertex.data.vertex_lat;
            s1_o2_reg      <= vertex.data.vertex_lon;
            s1_edge_reg    <= open_eff;
            s1_first_reg   <= first_eff;
            s1_last_reg    <= open_eff && in_last;
            s1_hit_reg     <= open_eff && in_hit;
            s1_restart_reg <= vertex.data.restart;
        end
    end

    // Compares against the test point and the two cross products.
    logic signed [LON_W:0]         dlon_edge;
    logic signed [LAT_W:0]         dlat_test;
    logic signed [LON_W:0]         dlon_test;
    logic signed [LAT_W:0]         dlat_edge;
    logic signed [LON_W+LAT_W+1:0] lhs;
    logic signed [LON_W+LAT_W+1:0] rhs;

    assign dlon_edge = $signed({s1_o2_reg[LON_W-1], s1_o2_reg})
                     - $signed({s1_o1_reg[LON_W-1], s1_o1_reg});
    assign dlat_test = $signed({test_lat_reg[LAT_W-1], test_lat_reg})
                     - $signed({s1_a1_reg[LAT_W-1], s1_a1_reg});
    assign dlon_test = $signed({test_lon_reg[LON_W-1], test_lon_reg})
                     - $signed({s1_o1_reg[LON_W-1], s1_o1_reg});
    assign dlat_edge = $signed({s1_a2_reg[LAT_W-1], s1_a2_reg})
                     - $signed({s1_a1_reg[LAT_W-1], s1_a1_reg});
    assign lhs       = dlon_edge * dlat_test;
    assign rhs       = dlon_test * dlat_edge;

    // ------------------------------------------------------------------
    // Stage 2: registered compares and products.
    // ------------------------------------------------------------------
    logic                          s2_a1_eq_reg;
    logic                          s2_a1_lt_reg;
    logic                          s2_a2_eq_reg;
    logic                          s2_a2_lt_reg;
    logic                          s2_o1_gt_reg;
    logic                          s2_o2_gt_reg;
    logic                          s2_dpos_reg;
    logic signed [LON_W+LAT_W+1:0] s2_lhs_reg;
    logic signed [LON_W+LAT_W+1:0] s2_rhs_reg;
    logic                          s2_edge_reg;
    logic                          s2_first_reg;
    logic                          s2_last_reg;
    logic                          s2_hit_reg;
    logic                          s2_restart_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_a1_eq_reg   <= s1_a1_reg == test_lat_reg;
            s2_a1_lt_reg   <= s1_a1_reg < test_lat_reg;
            s2_a2_eq_reg   <= s1_a2_reg == test_lat_reg;
            s2_a2_lt_reg   <= s1_a2_reg < test_lat_reg;
            s2_o1_gt_reg   <= s1_o1_reg > test_lon_reg;
            s2_o2_gt_reg   <= s1_o2_reg > test_lon_reg;
            s2_dpos_reg    <= s1_a2_reg > s1_a1_reg;
            s2_lhs_reg     <= lhs;
            s2_rhs_reg     <= rhs;
            s2_edge_reg    <= s1_edge_reg;
            s2_first_reg   <= s1_first_reg;
            s2_last_reg    <= s1_last_reg;
            s2_hit_reg     <= s1_hit_reg;
            s2_restart_reg <= s1_restart_reg;
        end
    end

    // Flag update against the running crossing state.
    edge_cmp_t cmp;
    flags_t    flags_reg;
    logic      hit_reg;
    flags_t    flags_base;
    flags_t    flags_edge;
    flags_t    flags_next;
    logic      hit_next;

    always_comb
    begin
        cmp.a1_eq = s2_a1_eq_reg;
        cmp.a1_lt = s2_a1_lt_reg;
        cmp.a2_eq = s2_a2_eq_reg;
        cmp.a2_lt = s2_a2_lt_reg;
        cmp.o1_gt = s2_o1_gt_reg;
        cmp.o2_gt = s2_o2_gt_reg;
        cmp.right = s2_dpos_reg ? (s2_lhs_reg > s2_rhs_reg) : (s2_lhs_reg < s2_rhs_reg);
        cmp.first = s2_first_reg;
        cmp.last  = s2_last_reg;
    end

    assign flags_base = s2_restart_reg ? '0 : flags_reg;

    pipc_edge_update u_edge_update (
        .flags_in  (flags_base),
        .cmp       (cmp),
        .flags_out (flags_edge)
    );

    assign flags_next = s2_edge_reg ? flags_edge : flags_base;
    assign hit_next   = (hit_reg && !s2_restart_reg) || (s2_edge_reg && s2_hit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else if (s2_adv)
        begin
            flags_reg <= flags_next;
            hit_reg   <= hit_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    result_t res_next;
    result_t res_reg;

    always_comb
    begin
        res_next.inside_res = hit_next || flags_next[FLAG_INSIDE];
        res_next.keep       = res_next.inside_res ^ exclude_mode_reg;
        res_next.closed     = s2_last_reg;
        res_next.unresolved = |flags_next[FLAG_BEGIN_HOR:FLAG_LIMBO];
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = res_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_closed_polygon_first: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> first_reg)
        else $error("first-edge flag not pending while no polygon is open");

    a_last_needs_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_last_reg) |-> s2_edge_reg)
        else $error("closing vertex without an edge");

    a_limbo_up: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg[FLAG_LIMBO_UP] |-> flags_reg[FLAG_LIMBO])
        else $error("limbo direction set without limbo");

    a_begin_up: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg[FLAG_BEGIN_UP] |-> flags_reg[FLAG_LIMBO_BEGIN])
        else $error("begin direction set without begin limbo");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> vertex.ready)
        else $error("vertex ready low with an empty result register");

    a_result_from_stage2: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_valid_reg))
        else $error("result appeared without a stage 2 item");

endmodule

@@ tb/sv/pipc_crossing_checker.sv @@
// ============================================================================
// pipc_crossing_checker
// Watches the configuration port and both channels of the point-in-polygon
// crossing block. It keeps its own copy of the test point, the exclude mode
// and the polygon state. For every accepted vertex item it works out the
// result the block must return. Each accepted result item is compared field
// by field with the oldest verdict still waiting.
// ============================================================================
module pipc_crossing_checker
    import pipc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  vertex_valid,
    input  logic                  vertex_ready,
    input  vertex_t               vertex_data,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  result_t               result_data,
    output int                    outstanding,
    output int                    errors
);

    // Shadow configuration.
    longint  test_lat;
    longint  test_lon;
    bit      exclude_mode;

    // Shadow polygon state.
    longint  start_lat;
    longint  start_lon;
    longint  prev_lat;
    longint  prev_lon;
    bit      polygon_open;
    bit      first_edge_pending;
    bit      vertex_hit;
    flags_t  crossing_flags;

    // Verdicts waiting for their result item.
    result_t verdicts_q[$];
    result_t oldest_verdict;
    int      mismatches;

    // Clears the polygon state; the configuration stays.
    function automatic void clear_polygon();
        start_lat          = 0;
        start_lon          = 0;
        prev_lat           = 0;
        prev_lon           = 0;
        polygon_open       = 1'b0;
        first_edge_pending = 1'b1;
        vertex_hit         = 1'b0;
        crossing_flags     = '0;
    endfunction

    // Flag update for one edge (a1,o1) -> (a2,o2) against the ray that runs
    // from (wa,wo) toward greater longitude.
    function automatic flags_t crossing_update(input flags_t f,
                                               input longint a1, input longint o1,
                                               input longint a2, input longint o2,
                                               input longint wa, input longint wo,
                                               input bit first_edge,
                                               input bit closing);
        flags_t s;
        longint d;
        longint lhs;
        longint rhs;
        bit     to_right;
        s = f;
        if (a1 == wa) begin
            if (a2 < wa) begin
                // Leaving the ray downward.
                if (s[FLAG_LIMBO]) begin
                    if (s[FLAG_LIMBO_UP])
                        s[FLAG_INSIDE] = !s[FLAG_INSIDE];
                    s[FLAG_LIMBO]    = 1'b0;
                    s[FLAG_LIMBO_UP] = 1'b0;
                end
                else if (s[FLAG_LIMBO_BEGIN]) begin
                    if (s[FLAG_BEGIN_HOR]) begin
                        s[FLAG_BEGIN_HOR] = 1'b0;
                    end
                    else if (closing) begin
                        if (s[FLAG_BEGIN_UP])
                            s[FLAG_INSIDE] = !s[FLAG_INSIDE];
                        s[FLAG_LIMBO_BEGIN] = 1'b0;
                        s[FLAG_BEGIN_UP]    = 1'b0;
                    end
                end
                else if (first_edge && o1 > wo) begin
                    s[FLAG_LIMBO_BEGIN] = 1'b1;
                end
            end
            else if (a2 == wa) begin
                // Horizontal edge lying on the ray line.
                if (first_edge && (o1 > wo || o2 > wo)) begin
                    s[FLAG_LIMBO_BEGIN] = 1'b1;
                    s[FLAG_BEGIN_HOR]   = 1'b1;
                end
                else if (closing && s[FLAG_LIMBO_BEGIN] && s[FLAG_LIMBO]) begin
                    if (s[FLAG_LIMBO_UP] != s[FLAG_BEGIN_UP])
                        s[FLAG_INSIDE] = !s[FLAG_INSIDE];
                    s[FLAG_LIMBO]       = 1'b0;
                    s[FLAG_LIMBO_UP]    = 1'b0;
                    s[FLAG_LIMBO_BEGIN] = 1'b0;
                    s[FLAG_BEGIN_UP]    = 1'b0;
                end
                else if (!s[FLAG_LIMBO] && o1 <= wo && o2 > wo) begin
                    if (s[FLAG_UP]) begin
                        s[FLAG_UP]       = 1'b0;
                        s[FLAG_LIMBO_UP] = 1'b1;
                    end
                    s[FLAG_LIMBO] = 1'b1;
                end
            end
            else begin
                // Leaving the ray upward.
                if (s[FLAG_LIMBO]) begin
                    if (!s[FLAG_LIMBO_UP])
                        s[FLAG_INSIDE] = !s[FLAG_INSIDE];
                    s[FLAG_LIMBO]    = 1'b0;
                    s[FLAG_LIMBO_UP] = 1'b0;
                end
                else if (s[FLAG_LIMBO_BEGIN]) begin
                    if (s[FLAG_BEGIN_HOR]) begin
                        s[FLAG_BEGIN_HOR] = 1'b0;
                        s[FLAG_BEGIN_UP]  = 1'b1;
                    end
                    else if (closing) begin
                        if (!s[FLAG_BEGIN_UP])
                            s[FLAG_INSIDE] = !s[FLAG_INSIDE];
                        s[FLAG_LIMBO_BEGIN] = 1'b0;
                        s[FLAG_BEGIN_UP]    = 1'b0;
                    end
                end
                else if (first_edge && o1 > wo) begin
                    s[FLAG_LIMBO_BEGIN] = 1'b1;
                    s[FLAG_BEGIN_UP]    = 1'b1;
                end
            end
            s[FLAG_UP] = 1'b0;
        end
        else if (a2 == wa) begin
            // Arriving on the ray line.
            if (a1 < wa) begin
                if (closing) begin
                    if (s[FLAG_BEGIN_UP])
                        s[FLAG_INSIDE] = !s[FLAG_INSIDE];
                    s[FLAG_LIMBO_BEGIN] = 1'b0;
                    s[FLAG_BEGIN_UP]    = 1'b0;
                end
                else if (o2 > wo) begin
                    s[FLAG_LIMBO] = 1'b1;
                end
            end
            else begin
                if (closing) begin
                    if (!s[FLAG_BEGIN_UP])
                        s[FLAG_INSIDE] = !s[FLAG_INSIDE];
                    s[FLAG_LIMBO_BEGIN] = 1'b0;
                    s[FLAG_BEGIN_UP]    = 1'b0;
                end
                else if (o2 > wo) begin
                    s[FLAG_LIMBO]    = 1'b1;
                    s[FLAG_LIMBO_UP] = 1'b1;
                end
                else begin
                    s[FLAG_UP] = 1'b1;
                end
            end
        end
        else if ((a1 > wa && a2 < wa) || (a1 < wa && a2 > wa)) begin
            // Edge straddles the ray line: find which side it crosses on.
            if (o1 > wo && o2 > wo) begin
                s[FLAG_INSIDE] = !s[FLAG_INSIDE];
            end
            else if (!(o1 <= wo && o2 <= wo)) begin
                d        = a2 - a1;
                lhs      = (o2 - o1) * (wa - a1);
                rhs      = (wo - o1) * d;
                to_right = (d > 0) ? (lhs > rhs) : (lhs < rhs);
                if (to_right)
                    s[FLAG_INSIDE] = !s[FLAG_INSIDE];
            end
        end
        return s;
    endfunction

    // Advances the shadow state by one vertex and returns its verdict.
    function automatic result_t predict_vertex(input vertex_t v);
        result_t r;
        longint  la;
        longint  lo;
        bit      closing;
        la      = longint'($signed(v.vertex_lat));
        lo      = longint'($signed(v.vertex_lon));
        closing = 1'b0;
        if (v.restart)
            clear_polygon();
        if (polygon_open) begin
            closing = (la == start_lat && lo == start_lon);
            if (la == test_lat && lo == test_lon)
                vertex_hit = 1'b1;
            crossing_flags = crossing_update(crossing_flags, prev_lat, prev_lon, la, lo,
                                             test_lat, test_lon, first_edge_pending,
                                             closing);
            first_edge_pending = 1'b0;
            if (closing) begin
                polygon_open       = 1'b0;
                first_edge_pending = 1'b1;
            end
            else begin
                prev_lat = la;
                prev_lon = lo;
            end
        end
        else begin
            // Opening vertex: nothing to test yet.
            start_lat    = la;
            start_lon    = lo;
            prev_lat     = la;
            prev_lon     = lo;
            polygon_open = 1'b1;
        end
        r.inside_res = vertex_hit | crossing_flags[FLAG_INSIDE];
        r.keep       = r.inside_res ^ exclude_mode;
        r.closed     = closing;
        r.unresolved = |crossing_flags[FLAG_BEGIN_HOR:FLAG_LIMBO];
        return r;
    endfunction

    // Compares one result field and reports a difference.
    function automatic void check_field(input string name, input bit want, input bit got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Track configuration writes, vertex items and result items.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            test_lat     = 0;
            test_lon     = 0;
            exclude_mode = 1'b0;
            clear_polygon();
            verdicts_q.delete();
            mismatches   = 0;
            outstanding <= 0;
            errors      <= 0;
        end
        else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_TEST_LAT:     test_lat = longint'($signed(cfg_data[LAT_W-1:0]));
                    CFG_TEST_LON:     test_lon = longint'($signed(cfg_data[LON_W-1:0]));
                    CFG_EXCLUDE_MODE: exclude_mode = cfg_data[0];
                    default:          ;
                endcase
            end
            if (vertex_valid && vertex_ready)
                verdicts_q.push_back(predict_vertex(vertex_data));
            if (result_valid && result_ready) begin
                if (verdicts_q.size() == 0) begin
                    $display("%0t: unexpected result item, expected none, actual %b",
                             $time, result_data);
                    mismatches++;
                end
                else begin
                    oldest_verdict = verdicts_q.pop_front();
                    check_field("inside_res", oldest_verdict.inside_res, result_data.inside_res);
                    check_field("keep", oldest_verdict.keep, result_data.keep);
                    check_field("closed", oldest_verdict.closed, result_data.closed);
                    check_field("unresolved", oldest_verdict.unresolved,
                                result_data.unresolved);
                end
            end
            outstanding <= verdicts_q.size();
            errors      <= mismatches;
        end
    end

endmodule

@@ tb/sv/tb_point_in_polygon_crossing_test_top.sv @@
// ============================================================================
// tb_point_in_polygon_crossing_test_top
// Stimulus and verdict for the point-in-polygon crossing block.
// ============================================================================
// A directed opener covers a plain square, a vertex on the test point, a
// horizontal edge on the ray, a ray through a vertex, and coordinate
// extremes with a repeated vertex in an open polygon. Random phases follow,
// each with its own test point and exclude mode. Most polygons sit on a
// small grid around the test point, so rays hit vertices and horizontal
// edges often; the rest are full-width polygons, open polygons and stray
// restarts. Both sides idle at random, with one long result stall and one
// stretch without idling. The checker beside the block predicts and
// compares every result.
// ============================================================================
module tb_point_in_polygon_crossing_test_top;

    import pipc_pkg::*;

    // Index with no register behind it; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 140;
    localparam int HOLD_CYCLES = 60;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pipc_stream_if #(.T(vertex_t)) vertex_ch ();
    pipc_stream_if #(.T(result_t)) result_ch ();

    int outstanding;
    int errors;
    int items_sent;
    int phase_end;
    int ph;
    bit sender_no_idle;
    bit receiver_no_idle;
    bit hold_req;

    point_in_polygon_crossing_test_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vertex    (vertex_ch),
        .result    (result_ch)
    );

    pipc_crossing_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .vertex_valid (vertex_ch.valid),
        .vertex_ready (vertex_ch.ready),
        .vertex_data  (vertex_ch.data),
        .result_valid (result_ch.valid),
        .result_ready (result_ch.ready),
        .result_data  (result_ch.data),
        .outstanding  (outstanding),
        .errors       (errors)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Overall time limit.
    initial
    begin
        #(20 * 300000);
        $display("tb: failure");
        $finish;
    end

    // Result receiver: random stalls, a no-stall mode and one long hold-off.
    initial
    begin : receiver
        int hold_left;
        bit hold_done;
        hold_left       = 0;
        hold_done       = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req && !hold_done) begin
                hold_done        = 1'b1;
                hold_left        = HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else if (receiver_no_idle) begin
                result_ch.ready <= 1'b1;
            end
            else begin
                result_ch.ready <= ($urandom_range(99) >= 26);
            end
        end
    end

    // Small signed grid offset in -3..3.
    function automatic longint grid_step();
        return longint'($urandom_range(6)) - 3;
    endfunction

    // Offers one vertex item, with random idle cycles ahead of it.
    task automatic send_vertex(input longint lat, input longint lon, input bit restart);
        vertex_t v;
        v.vertex_lat = lat[LAT_W-1:0];
        v.vertex_lon = lon[LON_W-1:0];
        v.restart    = restart;
        while (!sender_no_idle && $urandom_range(99) < 26) begin
            vertex_ch.valid <= 1'b0;
            @(posedge clk);
        end
        vertex_ch.valid <= 1'b1;
        vertex_ch.data  <= v;
        do @(posedge clk); while (!vertex_ch.ready);
        items_sent++;
    endtask

    // Stops offering and waits until every verdict has been matched.
    task automatic wait_drain();
        vertex_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all registers, plus one write to the unused index.
    task automatic set_config(input longint lat, input longint lon, input bit excl);
        bit spare_bit;
        spare_bit  = 1'($urandom_range(1));
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_TEST_LAT;
        cfg_data  <= {spare_bit, lat[LAT_W-1:0]};
        @(posedge clk);
        cfg_index <= CFG_TEST_LON;
        cfg_data  <= lon[LON_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_EXCLUDE_MODE;
        cfg_data  <= {31'($urandom_range(32'h7fff_ffff)), excl};
        @(posedge clk);
        cfg_index <= CFG_SPARE_IDX;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Polygon on a grid around (clat,clon), optionally closed.
    task automatic send_grid_polygon(input longint clat, input longint clon,
                                     input longint pitch, input int n,
                                     input bit fresh, input bit closeit);
        longint lat0;
        longint lon0;
        lat0 = clat + pitch * grid_step();
        lon0 = clon + pitch * grid_step();
        send_vertex(lat0, lon0, fresh);
        for (int i = 1; i < n; i++)
            send_vertex(clat + pitch * grid_step(), clon + pitch * grid_step(), 1'b0);
        if (closeit)
            send_vertex(lat0, lon0, 1'b0);
    endtask

    // Closed polygon with full-width random vertices.
    task automatic send_wide_polygon(input int n, input bit fresh);
        longint lat0;
        longint lon0;
        lat0 = longint'($urandom);
        lon0 = longint'($urandom);
        send_vertex(lat0, lon0, fresh);
        for (int i = 1; i < n; i++)
            send_vertex(longint'($urandom), longint'($urandom), 1'b0);
        send_vertex(lat0, lon0, 1'b0);
    endtask

    // One random polygon or noise item around the current test point.
    task automatic send_random_shape(input longint tlat, input longint tlon);
        longint pitch;
        int     pick;
        bit     fresh;
        fresh = ($urandom_range(9) < 3);
        case ($urandom_range(3))
            0:       pitch = 1;
            1:       pitch = longint'($urandom_range(1, 50));
            2:       pitch = longint'($urandom_range(1, 100000));
            default: pitch = 10000000;
        endcase
        pick = $urandom_range(99);
        if (pick < 70)
            send_grid_polygon(tlat, tlon, pitch, $urandom_range(3, 8), fresh, 1'b1);
        else if (pick < 85)
            send_wide_polygon($urandom_range(3, 6), fresh);
        else if (pick < 95)
            send_grid_polygon(tlat, tlon, pitch, $urandom_range(1, 5), fresh, 1'b0);
        else
            send_vertex(longint'($urandom), longint'($urandom), 1'b1);
    endtask

    // Main stimulus.
    initial
    begin : stimulus
        longint tlat;
        longint tlon;
        bit     excl;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        vertex_ch.valid  = 1'b0;
        vertex_ch.data   = '0;
        items_sent       = 0;
        sender_no_idle   = 1'b0;
        receiver_no_idle = 1'b0;
        hold_req         = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opener with the test point at the origin.
        set_config(0, 0, 1'b0);
        // Square around the test point.
        send_vertex(-1, -1, 1'b0);
        send_vertex(-1, 1, 1'b0);
        send_vertex(1, 1, 1'b0);
        send_vertex(1, -1, 1'b0);
        send_vertex(-1, -1, 1'b0);
        // Vertex lying on the test point.
        send_vertex(1, 1, 1'b1);
        send_vertex(0, 0, 1'b0);
        send_vertex(1, -1, 1'b0);
        send_vertex(1, 1, 1'b0);
        // Horizontal edge on the ray.
        send_vertex(-1, 1, 1'b1);
        send_vertex(0, 1, 1'b0);
        send_vertex(0, 3, 1'b0);
        send_vertex(1, 3, 1'b0);
        send_vertex(-1, 1, 1'b0);
        // Ray passing exactly through a vertex.
        send_vertex(-2, 1, 1'b1);
        send_vertex(0, 2, 1'b0);
        send_vertex(2, 1, 1'b0);
        send_vertex(-2, 1, 1'b0);
        // Coordinate extremes, a repeated vertex, left open.
        send_vertex(longint'(32'h3fff_ffff), longint'(32'h7fff_ffff), 1'b1);
        send_vertex(-(longint'(1) << 30), -(longint'(1) << 31), 1'b0);
        send_vertex(-(longint'(1) << 30), -(longint'(1) << 31), 1'b0);
        send_vertex(longint'(32'h3fff_ffff), -(longint'(1) << 31), 1'b0);
        wait_drain();

        // Random phases, each with its own test point.
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: begin tlat = -900000000; tlon = -1800000000; excl = 1'b1; end
                1: begin tlat = 900000000;  tlon = 1800000000;  excl = 1'b0; end
                2: begin tlat = -(longint'(1) << 30); tlon = longint'(32'h7fff_ffff);
                         excl = 1'b1; end
                3: begin tlat = longint'(32'h3fff_ffff); tlon = -(longint'(1) << 31);
                         excl = 1'b0; end
                default: begin
                    tlat = longint'($urandom_range(1800000000)) - 900000000;
                    tlon = longint'($urandom_range(32'hd693_a400)) - 1800000000;
                    excl = 1'($urandom_range(1));
                end
            endcase
            set_config(tlat, tlon, excl);
            phase_end = items_sent + PHASE_ITEMS;

            // Long result stall while items keep coming.
            if (ph == 1) begin
                sender_no_idle = 1'b1;
                hold_req       = 1'b1;
            end
            // A stretch with no idling on either side.
            if (ph == 3) begin
                sender_no_idle   = 1'b1;
                receiver_no_idle = 1'b1;
            end

            while (items_sent < phase_end) begin
                send_random_shape(tlat, tlon);
                if (items_sent >= phase_end - PHASE_ITEMS / 3) begin
                    sender_no_idle   = 1'b0;
                    receiver_no_idle = 1'b0;
                end
            end
            wait_drain();
        end

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
